// ===== rtl/core/slotted_page_directory_core_defines.svh =====
// Assertion macros used by the checker file of the slot directory core.
`ifndef SLOTTED_PAGE_DIRECTORY_CORE_DEFINES_SVH
`define SLOTTED_PAGE_DIRECTORY_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SPD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot directory check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot directory check failed");

`endif

// ===== rtl/core/spd_pkg.sv =====
package spd_pkg;

   // Page geometry.
   localparam int PAGE_BYTES   = 1024;
   localparam int HEADER_BYTES = 20;
   localparam int ENTRY_BYTES  = 4;
   localparam int MAX_SLOTS    = 256;

   localparam int SLOT_W  = 8;
   localparam int COUNT_W = 9;
   localparam int BYTE_W  = 10;

   localparam logic [BYTE_W-1:0]  FREE_RESET  = BYTE_W'(PAGE_BYTES - HEADER_BYTES);
   localparam logic [COUNT_W-1:0] SLOTS_LIMIT = COUNT_W'(MAX_SLOTS);

   // Operation codes.
   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_DELETE = 3'd1;
   localparam logic [2:0] OP_GET    = 3'd2;
   localparam logic [2:0] OP_FIRST  = 3'd3;
   localparam logic [2:0] OP_NEXT   = 3'd4;
   localparam logic [2:0] OP_CLEAR  = 3'd5;

   // Status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOSPACE   = 3'd1;
   localparam logic [2:0] ST_INVALID   = 3'd2;
   localparam logic [2:0] ST_NORECORDS = 3'd3;
   localparam logic [2:0] ST_ENDPAGE   = 3'd4;

   typedef struct packed {
      logic [2:0]  operation;
      logic [9:0]  record_length;
      logic [30:0] page_id;
      logic [7:0]  slot_number;
   } spd_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] result_slot;
      logic [9:0] record_offset;
      logic [9:0] length_out;
   } spd_rsp_type;

   // One directory entry as stored in the slot memory.
   typedef struct packed {
      logic              used;
      logic [BYTE_W-1:0] length;
      logic [BYTE_W-1:0] offset;
   } spd_entry_type;

   localparam int ENTRY_W = $bits(spd_entry_type);

endpackage

// ===== rtl/core/slotted_page_directory_core.sv =====
// Channel   Direction  Payload            Transfer
// req_      in         spd_req_type       req_valid & req_ready
// rsp_      out        spd_rsp_type       rsp_valid & rsp_ready
// csr_      in         31-bit page number csr_write_enable
//
// One item at a time. Get reads the addressed entry only; insert and first
// scan the entries below the slot count, next those above its start slot, and
// delete, unless the page empties, those below the slot count after its read.
// The scans walk the single slot memory read port one entry per cycle.
// Reset is synchronous; the slot memory needs no clearing pass.
// A stalled response sits in the output register while the next request runs.
module slotted_page_directory_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  spd_pkg::spd_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output spd_pkg::spd_rsp_type rsp_data,
   input  logic                csr_write_enable,
   input  logic [30:0]         csr_write_data
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_START     = 3'd1;
   localparam logic [2:0] S_READ      = 3'd2;
   localparam logic [2:0] S_SCAN_INS  = 3'd3;
   localparam logic [2:0] S_SCAN_USED = 3'd4;
   localparam logic [2:0] S_SCAN_DEL  = 3'd5;
   localparam logic [2:0] S_RESP      = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [30:0] page_ff, page_in;
   spd_pkg::spd_req_type item_ff, item_in;
   spd_pkg::spd_rsp_type res_ff, res_in;
   spd_pkg::spd_rsp_type rsp_data_ff, rsp_data_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [spd_pkg::COUNT_W-1:0] alloc_ff, alloc_in;
   logic [spd_pkg::BYTE_W-1:0]  fp_ff, fp_in;
   logic [spd_pkg::BYTE_W-1:0]  fb_ff, fb_in;
   logic [spd_pkg::COUNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic [spd_pkg::COUNT_W-1:0] chk_idx_ff, chk_idx_in;
   logic        chk_valid_ff, chk_valid_in;
   logic [spd_pkg::BYTE_W-1:0]  del_off_ff, del_off_in;
   logic [spd_pkg::BYTE_W-1:0]  del_len_ff, del_len_in;

   logic                        ram_wr_en;
   logic [spd_pkg::SLOT_W-1:0]  ram_wr_addr;
   spd_pkg::spd_entry_type      ram_wr_entry;
   logic [spd_pkg::SLOT_W-1:0]  ram_rd_addr;
   logic [spd_pkg::ENTRY_W-1:0] ram_rd_data;
   spd_pkg::spd_entry_type      rd_entry;

   logic        scan_issue;
   logic        scan_done;
   logic [spd_pkg::BYTE_W:0]    len_ext;
   logic [spd_pkg::BYTE_W:0]    append_need;
   logic [spd_pkg::BYTE_W-1:0]  fp_after_del;

   spd_ram #(
      .WIDTH (spd_pkg::ENTRY_W),
      .DEPTH (spd_pkg::MAX_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = spd_pkg::spd_entry_type'(ram_rd_data);

   // Scan bookkeeping: a read is issued while entries remain below the slot
   // count, and the scan is over once the last read data has been checked.
   assign scan_issue  = scan_idx_ff < alloc_ff;
   assign scan_done   = !chk_valid_ff && !scan_issue;
   assign len_ext     = {1'b0, item_ff.record_length};
   assign append_need = len_ext + (spd_pkg::BYTE_W + 1)'(spd_pkg::ENTRY_BYTES);
   assign fp_after_del = (fp_ff >= rd_entry.length) ? fp_ff - rd_entry.length : '0;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer with read, modify and write back of slot entries.
   always_comb begin
      state_in     = state_ff;
      page_in      = csr_write_enable ? csr_write_data : page_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      alloc_in     = alloc_ff;
      fp_in        = fp_ff;
      fb_in        = fb_ff;
      scan_idx_in  = scan_idx_ff;
      chk_idx_in   = chk_idx_ff;
      chk_valid_in = chk_valid_ff;
      del_off_in   = del_off_ff;
      del_len_in   = del_len_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = chk_idx_ff[spd_pkg::SLOT_W-1:0];
      ram_wr_entry = rd_entry;
      ram_rd_addr  = scan_idx_ff[spd_pkg::SLOT_W-1:0];
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // All scan states advance the read pipeline the same way.
      if (state_ff == S_SCAN_INS || state_ff == S_SCAN_USED || state_ff == S_SCAN_DEL) begin
         chk_valid_in = scan_issue;
         chk_idx_in   = scan_idx_ff;
         scan_idx_in  = scan_idx_ff + (spd_pkg::COUNT_W)'(scan_issue);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = S_START;
            end
         end

         S_START: begin
            res_in       = '0;
            res_in.status = spd_pkg::ST_OK;
            scan_idx_in  = '0;
            chk_valid_in = 1'b0;
            ram_rd_addr  = item_ff.slot_number;
            unique case (item_ff.operation) inside
               spd_pkg::OP_INSERT: begin
                  if (fb_ff < item_ff.record_length) begin
                     res_in.status = spd_pkg::ST_NOSPACE;
                     state_in      = S_RESP;
                  end else begin
                     state_in = S_SCAN_INS;
                  end
               end
               spd_pkg::OP_DELETE, spd_pkg::OP_GET: begin
                  if (item_ff.page_id != page_ff ||
                      {1'b0, item_ff.slot_number} >= alloc_ff) begin
                     res_in.status = spd_pkg::ST_INVALID;
                     state_in      = S_RESP;
                  end else begin
                     state_in = S_READ;
                  end
               end
               spd_pkg::OP_FIRST: begin
                  state_in = S_SCAN_USED;
               end
               spd_pkg::OP_NEXT: begin
                  if ({1'b0, item_ff.slot_number} >= alloc_ff) begin
                     res_in.status = spd_pkg::ST_ENDPAGE;
                     state_in      = S_RESP;
                  end else begin
                     scan_idx_in = {1'b0, item_ff.slot_number} + 9'd1;
                     state_in    = S_SCAN_USED;
                  end
               end
               spd_pkg::OP_CLEAR: begin
                  alloc_in = '0;
                  fp_in    = '0;
                  fb_in    = spd_pkg::FREE_RESET;
                  state_in = S_RESP;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end

         // Entry of the addressed slot is on the read port.
         S_READ: begin
            if (!rd_entry.used) begin
               res_in.status = spd_pkg::ST_INVALID;
               state_in      = S_RESP;
            end else begin
               res_in.record_offset = rd_entry.offset;
               res_in.length_out    = rd_entry.length;
               if (item_ff.operation == spd_pkg::OP_GET) begin
                  state_in = S_RESP;
               end else begin
                  // Delete: free the slot and give back its bytes.
                  del_off_in        = rd_entry.offset;
                  del_len_in        = rd_entry.length;
                  fb_in             = fb_ff + rd_entry.length;
                  fp_in             = fp_after_del;
                  ram_wr_en         = 1'b1;
                  ram_wr_addr       = item_ff.slot_number;
                  ram_wr_entry      = rd_entry;
                  ram_wr_entry.used = 1'b0;
                  if (fp_after_del == '0) begin
                     res_in.status = spd_pkg::ST_NORECORDS;
                     state_in      = S_RESP;
                  end else begin
                     scan_idx_in  = '0;
                     chk_valid_in = 1'b0;
                     state_in     = S_SCAN_DEL;
                  end
               end
            end
         end

         // Look for the lowest free slot, else append one.
         S_SCAN_INS: begin
            ram_wr_entry.used   = 1'b1;
            ram_wr_entry.length = item_ff.record_length;
            ram_wr_entry.offset = fp_ff;
            if (chk_valid_ff && !rd_entry.used) begin
               ram_wr_en            = 1'b1;
               fp_in                = fp_ff + item_ff.record_length;
               fb_in                = fb_ff - item_ff.record_length;
               res_in.result_slot   = chk_idx_ff[spd_pkg::SLOT_W-1:0];
               res_in.record_offset = fp_ff;
               res_in.length_out    = item_ff.record_length;
               state_in             = S_RESP;
            end else if (scan_done) begin
               if ({1'b0, fb_ff} < append_need || alloc_ff >= spd_pkg::SLOTS_LIMIT) begin
                  res_in.status = spd_pkg::ST_NOSPACE;
               end else begin
                  ram_wr_en            = 1'b1;
                  ram_wr_addr          = alloc_ff[spd_pkg::SLOT_W-1:0];
                  alloc_in             = alloc_ff + 9'd1;
                  fp_in                = fp_ff + item_ff.record_length;
                  fb_in                = fb_ff - append_need[spd_pkg::BYTE_W-1:0];
                  res_in.result_slot   = alloc_ff[spd_pkg::SLOT_W-1:0];
                  res_in.record_offset = fp_ff;
                  res_in.length_out    = item_ff.record_length;
               end
               state_in = S_RESP;
            end
         end

         // First and next: look for the lowest used slot from the start index.
         S_SCAN_USED: begin
            if (chk_valid_ff && rd_entry.used) begin
               res_in.result_slot = chk_idx_ff[spd_pkg::SLOT_W-1:0];
               state_in           = S_RESP;
            end else if (scan_done) begin
               res_in.status = (item_ff.operation == spd_pkg::OP_FIRST) ?
                               spd_pkg::ST_NORECORDS : spd_pkg::ST_ENDPAGE;
               state_in      = S_RESP;
            end
         end

         // Move records above the removed one down by its length. Reads run
         // ahead of writes, so no entry is read after its own update.
         S_SCAN_DEL: begin
            ram_wr_entry.offset = rd_entry.offset - del_len_ff;
            if (chk_valid_ff && rd_entry.used && rd_entry.offset > del_off_ff) begin
               ram_wr_en = 1'b1;
            end
            if (scan_done) begin
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and page state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         page_ff      <= '0;
         alloc_ff     <= '0;
         fp_ff        <= '0;
         fb_ff        <= spd_pkg::FREE_RESET;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         page_ff      <= page_in;
         alloc_ff     <= alloc_in;
         fp_ff        <= fp_in;
         fb_ff        <= fb_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      scan_idx_ff <= scan_idx_in;
      chk_idx_ff  <= chk_idx_in;
      del_off_ff  <= del_off_in;
      del_len_ff  <= del_len_in;
   end

endmodule

// ===== rtl/core/spd_ram.sv =====
module spd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/spd_checker.sv =====
`include "slotted_page_directory_core_defines.svh"

module spd_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input spd_pkg::spd_rsp_type rsp_data
);

   // A response that is not taken stays and keeps its payload.
   `SPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // Status codes stay within the defined set.
   `SPD_ASSERT_NOW(a_status_range, clock, reset, rsp_valid, rsp_data.status <= spd_pkg::ST_ENDPAGE)

   // Failures other than an emptied page carry no slot, offset or length.
   `SPD_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && (rsp_data.status == spd_pkg::ST_NOSPACE || rsp_data.status == spd_pkg::ST_INVALID || rsp_data.status == spd_pkg::ST_ENDPAGE), rsp_data.result_slot == 8'd0 && rsp_data.record_offset == 10'd0 && rsp_data.length_out == 10'd0)

   // The block works on one request at a time.
   `SPD_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind slotted_page_directory_core spd_checker u_spd_checker (.*);

// ===== dv/spd_result_checker.sv =====
// Watches both channels of the slot directory core and the page number
// register, predicts every response from its own copy of the directory
// and compares each response transfer against the oldest prediction.
module spd_result_checker
   import spd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  spd_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  spd_rsp_type rsp_data,
   input  logic        csr_write_enable,
   input  logic [30:0] csr_write_data,
   output int          failures,
   output int          pending
);

   // Shadow copy of the page directory and its bookkeeping.
   logic [BYTE_W-1:0] dir_offset [MAX_SLOTS];
   logic [BYTE_W-1:0] dir_length [MAX_SLOTS];
   bit                dir_used   [MAX_SLOTS];
   int                slot_count;
   int                fill_ptr;
   int                free_space;
   logic [30:0]       page_num;

   spd_rsp_type awaited_responses [$];
   spd_rsp_type want;

   initial begin
      for (int k = 0; k < MAX_SLOTS; k++) begin
         dir_offset[k] = '0;
         dir_length[k] = '0;
         dir_used[k]   = 1'b0;
      end
   end

   // Applies one operation to the shadow directory and returns its response.
   function automatic spd_rsp_type predict_response(input spd_req_type r);
      spd_rsp_type a;
      int          len;
      int          slot;
      int          pick;
      int          dlen;
      int          doff;
      bit          hit;
      bit          target_ok;
      a = '0;
      a.status = ST_OK;
      len = int'(r.record_length);
      slot = int'(r.slot_number);
      hit = 1'b0;
      pick = 0;
      target_ok = (r.page_id == page_num) && (slot < slot_count) && dir_used[slot];
      case (r.operation)
         OP_INSERT: begin
            if (free_space < len) begin
               a.status = ST_NOSPACE;
            end else begin
               // The lowest free slot is reused before a new one is appended.
               for (int k = 0; k < slot_count; k++) begin
                  if (!hit && !dir_used[k]) begin
                     hit = 1'b1;
                     pick = k;
                  end
               end
               if (!hit && (free_space < len + ENTRY_BYTES || slot_count >= MAX_SLOTS)) begin
                  a.status = ST_NOSPACE;
               end else begin
                  if (!hit) begin
                     pick = slot_count;
                     slot_count++;
                     free_space -= ENTRY_BYTES;
                  end
                  dir_length[pick] = r.record_length;
                  dir_offset[pick] = BYTE_W'(fill_ptr);
                  dir_used[pick]   = 1'b1;
                  fill_ptr += len;
                  free_space -= len;
                  a.result_slot   = 8'(pick);
                  a.record_offset = dir_offset[pick];
                  a.length_out    = r.record_length;
               end
            end
         end
         OP_DELETE: begin
            if (!target_ok) begin
               a.status = ST_INVALID;
            end else begin
               dlen = int'(dir_length[slot]);
               doff = int'(dir_offset[slot]);
               a.record_offset = BYTE_W'(doff);
               a.length_out    = BYTE_W'(dlen);
               free_space += dlen;
               fill_ptr = (fill_ptr >= dlen) ? fill_ptr - dlen : 0;
               dir_used[slot] = 1'b0;
               // An emptied page keeps the stale offsets of the other slots.
               if (fill_ptr == 0) begin
                  a.status = ST_NORECORDS;
               end else begin
                  for (int k = 0; k < slot_count; k++) begin
                     if (dir_used[k] && int'(dir_offset[k]) > doff) begin
                        dir_offset[k] = BYTE_W'(int'(dir_offset[k]) - dlen);
                     end
                  end
               end
            end
         end
         OP_GET: begin
            if (!target_ok) begin
               a.status = ST_INVALID;
            end else begin
               a.record_offset = dir_offset[slot];
               a.length_out    = dir_length[slot];
            end
         end
         OP_FIRST: begin
            a.status = ST_NORECORDS;
            for (int k = 0; k < slot_count; k++) begin
               if (!hit && dir_used[k]) begin
                  hit = 1'b1;
                  a.status = ST_OK;
                  a.result_slot = 8'(k);
               end
            end
         end
         OP_NEXT: begin
            // The scan neither checks the page id nor the mark of the start slot.
            a.status = ST_ENDPAGE;
            if (slot < slot_count) begin
               for (int k = slot + 1; k < slot_count; k++) begin
                  if (!hit && dir_used[k]) begin
                     hit = 1'b1;
                     a.status = ST_OK;
                     a.result_slot = 8'(k);
                  end
               end
            end
         end
         OP_CLEAR: begin
            slot_count = 0;
            fill_ptr   = 0;
            free_space = PAGE_BYTES - HEADER_BYTES;
         end
         default: begin
            // Spare operation codes leave the page alone and answer ok.
         end
      endcase
      return a;
   endfunction

   task automatic check_field(input string name, input logic [9:0] want_v,
                              input logic [9:0] got_v);
      if (got_v !== want_v) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      end
   endtask

   // Responses are matched before requests so that a response never meets
   // the prediction of a request taken in the same cycle.
   always @(posedge clock) begin
      if (reset) begin
         page_num   = '0;
         slot_count = 0;
         fill_ptr   = 0;
         free_space = PAGE_BYTES - HEADER_BYTES;
         failures   = 0;
         awaited_responses.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_responses.size() == 0) begin
               failures++;
               $display("%0t: response transfer with nothing expected, actual status %0d",
                        $time, rsp_data.status);
            end else begin
               want = awaited_responses.pop_front();
               check_field("status", 10'(want.status), 10'(rsp_data.status));
               check_field("result_slot", 10'(want.result_slot),
                           10'(rsp_data.result_slot));
               check_field("record_offset", want.record_offset, rsp_data.record_offset);
               check_field("length_out", want.length_out, rsp_data.length_out);
            end
         end
         if (csr_write_enable) begin
            page_num = csr_write_data;
         end
         if (req_valid && req_ready) begin
            awaited_responses.push_back(predict_response(req_data));
         end
      end
      pending = awaited_responses.size();
   end

endmodule

// ===== dv/tb.sv =====
module tb;
   import spd_pkg::*;

   // Spare operation codes that the core must answer without any change.
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   localparam logic [30:0] PAGE_ALL_ONES = 31'h7FFF_FFFF;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_ready;
   spd_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   spd_rsp_type rsp_data;
   logic        csr_write_enable;
   logic [30:0] csr_write_data;

   int          failures;
   int          pending;

   logic [30:0] page_now;
   int          slot_bound;
   bit          hold_off_request;
   bit          hold_off_done;
   bit          calm_window;

   slotted_page_directory_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   spd_result_checker result_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the core hangs.
   initial begin
      #25_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Response side: random back-pressure, one long hold-off on request and
   // a calm window with no stalls at all.
   initial begin
      rsp_ready = 1'b0;
      hold_off_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request && !hold_off_done) begin
            rsp_ready <= 1'b0;
            repeat (800) @(posedge clock);
            hold_off_done = 1'b1;
         end else begin
            rsp_ready <= calm_window || ($urandom_range(99) >= 26);
            @(posedge clock);
         end
      end
   end

   function automatic spd_req_type make_req(input logic [2:0] op, input int len,
                                            input logic [30:0] pid, input int slot);
      spd_req_type r;
      r.operation     = op;
      r.record_length = 10'(len);
      r.page_id       = pid;
      r.slot_number   = 8'(slot);
      return r;
   endfunction

   // Mostly well-formed traffic: the matching page id and slots that have
   // likely been allocated, with some foreign ids and wild slot numbers.
   function automatic spd_req_type random_item(input int len_cap, input bit allow_clear);
      spd_req_type r;
      int          pick;
      int          lsel;
      pick = $urandom_range(999);
      lsel = $urandom_range(99);
      if (pick < 450) begin
         r.operation = OP_INSERT;
      end else if (pick < 650) begin
         r.operation = OP_DELETE;
      end else if (pick < 780) begin
         r.operation = OP_GET;
      end else if (pick < 850) begin
         r.operation = OP_FIRST;
      end else if (pick < 975 || (pick < 990 && !allow_clear)) begin
         r.operation = OP_NEXT;
      end else if (pick < 990) begin
         r.operation = OP_CLEAR;
      end else begin
         r.operation = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
      end
      if (lsel < 75) begin
         r.record_length = 10'($urandom_range(len_cap));
      end else if (lsel < 95) begin
         r.record_length = 10'($urandom_range(200));
      end else begin
         r.record_length = 10'($urandom_range(1004));
      end
      r.page_id = ($urandom_range(99) < 90) ? page_now : 31'($urandom());
      r.slot_number = ($urandom_range(99) < 88) ? 8'($urandom_range(slot_bound))
                                               : 8'($urandom());
      return r;
   endfunction

   // Offers one request, holds it until the transfer, then, unless steady, idles at random.
   task automatic send(input spd_req_type item, input bit steady);
      int gap;
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (item.operation == OP_INSERT && slot_bound < 255) begin
         slot_bound++;
      end else if (item.operation == OP_CLEAR) begin
         slot_bound = 0;
      end
      gap = 0;
      if (!steady) begin
         while (gap < 12 && $urandom_range(99) < 26) gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Lets every outstanding response drain so the core is idle.
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_page(input logic [30:0] value);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      page_now = value;
   endtask

   initial begin
      logic [30:0] page_plan [4];
      int          len_plan  [4];
      bit          steady;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      hold_off_request = 1'b0;
      calm_window      = 1'b0;
      page_now         = '0;
      slot_bound       = 0;
      page_plan[0] = PAGE_ALL_ONES;
      page_plan[1] = '0;
      page_plan[2] = 31'($urandom());
      page_plan[3] = 31'd1;
      len_plan[0] = 24;
      len_plan[1] = 24;
      len_plan[2] = 3;
      len_plan[3] = 60;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part on the reset page number: empty page, no-space cases,
      // reuse of a freed slot, a delete that empties the page, spare codes.
      send(make_req(OP_FIRST, 0, '0, 0), 1'b0);
      send(make_req(OP_NEXT, 0, '0, 0), 1'b0);
      send(make_req(OP_GET, 0, '0, 0), 1'b0);
      send(make_req(OP_DELETE, 0, '0, 0), 1'b0);
      send(make_req(OP_INSERT, 0, '0, 0), 1'b0);
      send(make_req(OP_INSERT, 1000, '0, 0), 1'b0);
      send(make_req(OP_INSERT, 996, '0, 0), 1'b0);
      send(make_req(OP_INSERT, 0, '0, 0), 1'b0);
      send(make_req(OP_GET, 0, '0, 1), 1'b0);
      send(make_req(OP_GET, 0, PAGE_ALL_ONES, 1), 1'b0);
      send(make_req(OP_NEXT, 0, '0, 0), 1'b0);
      send(make_req(OP_NEXT, 0, '0, 255), 1'b0);
      send(make_req(OP_FIRST, 0, '0, 0), 1'b0);
      send(make_req(OP_DELETE, 0, '0, 0), 1'b0);
      send(make_req(OP_INSERT, 0, '0, 0), 1'b0);
      send(make_req(OP_DELETE, 0, '0, 1), 1'b0);
      send(make_req(OP_GET, 0, '0, 0), 1'b0);
      send(make_req(OP_DELETE, 0, '0, 0), 1'b0);
      send(make_req(OP_GET, 0, '0, 0), 1'b0);
      send(make_req(OP_SPARE_A, 1004, PAGE_ALL_ONES, 255), 1'b0);
      send(make_req(OP_SPARE_B, 0, '0, 0), 1'b0);
      send(make_req(OP_CLEAR, 0, '0, 0), 1'b0);
      send(make_req(OP_INSERT, 1004, '0, 0), 1'b0);
      send(make_req(OP_INSERT, 1000, '0, 0), 1'b0);
      send(make_req(OP_DELETE, 0, PAGE_ALL_ONES, 255), 1'b0);
      settle();

      // Random phases, each under its own page number. The third phase uses
      // tiny records without clears so that the directory grows.
      for (int phase = 0; phase < 4; phase++) begin
         write_page(page_plan[phase]);
         for (int n = 0; n < 350; n++) begin
            steady = (phase == 2 && n >= 40 && n < 190);
            calm_window <= steady;
            if (phase == 1 && n == 100) begin
               hold_off_request <= 1'b1;
            end
            send(random_item(len_plan[phase], phase != 2), steady);
         end
         settle();
      end

      repeat (300) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
